// ===== rtl/sic_pkg.sv =====
// ============================================================================
// sic_pkg
// Widths and pipeline constants shared by the segment intersection core.
// ============================================================================
`default_nettype none

package sic_pkg;

    // Coordinate width and fraction bits of the crossing point
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    // Output point width and quotient magnitude bits below the sign
    localparam int OUT_BITS = 32;
    localparam int QB       = OUT_BITS - 1;

    // Derived datapath widths
    localparam int DW   = COORD_BITS + 1;      // coordinate difference
    localparam int PW   = 2 * DW;              // product of two differences
    localparam int CPW  = 2 * COORD_BITS;      // product of two coordinates
    localparam int CCW  = CPW + 1;             // line constant c
    localparam int CW   = PW + 1;              // cross product, determinant
    localparam int NPW  = DW + CCW;            // b*c product
    localparam int NW   = NPW + 1;             // numerator

    // Divider depth: operand stage, one stage per quotient bit, output stage
    localparam int DIV_LAT = QB + 2;

endpackage

`default_nettype wire

// ===== rtl/sic_fixdiv.sv =====
// ============================================================================
// sic_fixdiv
// Pipelined restoring divider: trunc(num * 2^FRAC_BITS / den), signed result
// saturated to OUT_BITS. One quotient bit per stage, one operand per cycle.
// ============================================================================
`default_nettype none

module sic_fixdiv
    import sic_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic [NW-1:0]               num_mag,
    input  wire logic [CW-1:0]               den_mag,
    input  wire logic                        neg,
    output logic signed [OUT_BITS-1:0]       quo
);

    localparam int NMW  = NW + FRAC_BITS;
    localparam int NXW  = (NMW > QB) ? NMW : QB + 1;
    localparam int TW   = NXW - QB;
    localparam int CMPW = (TW > CW) ? TW : CW;

    logic [NXW-1:0]  nfull;
    logic [TW-1:0]   ntop;
    logic            ovf_next;

    logic [CW-1:0]   rem_reg [0:QB];
    logic [QB-1:0]   low_reg [0:QB];
    logic [QB-1:0]   q_reg   [0:QB];
    logic [CW-1:0]   den_reg [0:QB];
    logic            ovf_reg [0:QB];
    logic            neg_reg [0:QB];

    logic [CW:0]     trial   [1:QB];
    logic            ge      [1:QB];
    logic [CW:0]     diff    [1:QB];

    logic signed [OUT_BITS-1:0] quo_reg;

    // Quotient of 2^QB or more saturates either way
    always_comb
    begin
        nfull    = NXW'(num_mag) << FRAC_BITS;
        ntop     = nfull[NXW-1:QB];
        ovf_next = CMPW'(ntop) >= CMPW'(den_mag);
    end

    always_comb
    begin
        for (int k = 1; k <= QB; k++)
        begin
            trial[k] = {rem_reg[k-1], low_reg[k-1][QB-k]};
            ge[k]    = trial[k] >= {1'b0, den_reg[k-1]};
            diff[k]  = trial[k] - {1'b0, den_reg[k-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= CW'(ntop);
        low_reg[0] <= nfull[QB-1:0];
        q_reg[0]   <= '0;
        den_reg[0] <= den_mag;
        ovf_reg[0] <= ovf_next;
        neg_reg[0] <= neg;
        for (int k = 1; k <= QB; k++)
        begin
            rem_reg[k] <= ge[k] ? diff[k][CW-1:0] : trial[k][CW-1:0];
            low_reg[k] <= low_reg[k-1];
            q_reg[k]   <= {q_reg[k-1][QB-2:0], ge[k]};
            den_reg[k] <= den_reg[k-1];
            ovf_reg[k] <= ovf_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
        end
        if (ovf_reg[QB])
            quo_reg <= neg_reg[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
        else if (neg_reg[QB])
            quo_reg <= -$signed({1'b0, q_reg[QB]});
        else
            quo_reg <= $signed({1'b0, q_reg[QB]});
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/segment_intersection_core.sv =====
// ============================================================================
// segment_intersection_core
// Segment meet test and Q16.16 crossing point of the carrying lines.
// ============================================================================
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   ------------------------
//  input     a_/b_ start/end x/y                     start && !busy
//  result    meets, parallel, cross_x, cross_y       done, one cycle, no stall
//
// One transaction enters per cycle; busy is always low. From accept to done
// a transaction passes five arithmetic stages, the bit-per-stage divider,
// and the output register. The divider depth, one stage per quotient bit,
// sets the latency. Reset clears only the valid bits; data registers run
// free. The receiver cannot stall, so nothing ever holds.
// ============================================================================
`default_nettype none

module segment_intersection_core
    import sic_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_BITS-1:0]  a_start_x,
    input  wire logic signed [COORD_BITS-1:0]  a_start_y,
    input  wire logic signed [COORD_BITS-1:0]  a_end_x,
    input  wire logic signed [COORD_BITS-1:0]  a_end_y,
    input  wire logic signed [COORD_BITS-1:0]  b_start_x,
    input  wire logic signed [COORD_BITS-1:0]  b_start_y,
    input  wire logic signed [COORD_BITS-1:0]  b_end_x,
    input  wire logic signed [COORD_BITS-1:0]  b_end_y,
    output logic                               done,
    output logic                               meets,
    output logic                               parallel,
    output logic signed [OUT_BITS-1:0]         cross_x,
    output logic signed [OUT_BITS-1:0]         cross_y
);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DW-1:0]         diff_t;

    // ---- stage 1: differences, coordinate products, bounding box ----
    logic  v1_reg;
    diff_t d23x_reg, d23y_reg, d43x_reg, d43y_reg, d13x_reg, d13y_reg;
    diff_t d41x_reg, d41y_reg, d21x_reg, d21y_reg;
    diff_t a12_reg, a34_reg;
    logic signed [CPW-1:0] p12_reg, p21_reg, p34_reg, p43_reg;
    logic  box_reg;
    logic  box_next;
    coord_t lo_ax, hi_ax, lo_ay, hi_ay, lo_bx, hi_bx, lo_by, hi_by;
    coord_t lo_x, hi_x, lo_y, hi_y;

    // Overlap test of the axis-aligned boxes, edges included
    always_comb
    begin
        lo_ax = (a_start_x < a_end_x) ? a_start_x : a_end_x;
        hi_ax = (a_start_x < a_end_x) ? a_end_x : a_start_x;
        lo_ay = (a_start_y < a_end_y) ? a_start_y : a_end_y;
        hi_ay = (a_start_y < a_end_y) ? a_end_y : a_start_y;
        lo_bx = (b_start_x < b_end_x) ? b_start_x : b_end_x;
        hi_bx = (b_start_x < b_end_x) ? b_end_x : b_start_x;
        lo_by = (b_start_y < b_end_y) ? b_start_y : b_end_y;
        hi_by = (b_start_y < b_end_y) ? b_end_y : b_start_y;
        lo_x  = (lo_ax > lo_bx) ? lo_ax : lo_bx;
        hi_x  = (hi_ax < hi_bx) ? hi_ax : hi_bx;
        lo_y  = (lo_ay > lo_by) ? lo_ay : lo_by;
        hi_y  = (hi_ay < hi_by) ? hi_ay : hi_by;
        box_next = (lo_x <= hi_x) && (lo_y <= hi_y);
    end

    always_ff @(posedge clk)
    begin
        d23x_reg <= DW'(a_end_x) - DW'(b_start_x);
        d23y_reg <= DW'(a_end_y) - DW'(b_start_y);
        d43x_reg <= DW'(b_end_x) - DW'(b_start_x);
        d43y_reg <= DW'(b_end_y) - DW'(b_start_y);
        d13x_reg <= DW'(a_start_x) - DW'(b_start_x);
        d13y_reg <= DW'(a_start_y) - DW'(b_start_y);
        d41x_reg <= DW'(b_end_x) - DW'(a_start_x);
        d41y_reg <= DW'(b_end_y) - DW'(a_start_y);
        d21x_reg <= DW'(a_end_x) - DW'(a_start_x);
        d21y_reg <= DW'(a_end_y) - DW'(a_start_y);
        a12_reg  <= DW'(a_start_y) - DW'(a_end_y);
        a34_reg  <= DW'(b_start_y) - DW'(b_end_y);
        p12_reg  <= CPW'(a_start_x) * CPW'(a_end_y);
        p21_reg  <= CPW'(a_end_x) * CPW'(a_start_y);
        p34_reg  <= CPW'(b_start_x) * CPW'(b_end_y);
        p43_reg  <= CPW'(b_end_x) * CPW'(b_start_y);
        box_reg  <= box_next;
    end

    // ---- stage 2: cross-product terms, determinant terms, line constants ----
    logic v2_reg;
    logic signed [PW-1:0] m1a_reg, m1b_reg, m2a_reg, m2b_reg;
    logic signed [PW-1:0] m3a_reg, m3b_reg, m4a_reg, m4b_reg;
    logic signed [PW-1:0] da_reg, db_reg;
    logic signed [CCW-1:0] c12_reg, c34_reg;
    diff_t a12_2_reg, a34_2_reg, b12_2_reg, b34_2_reg;
    logic box2_reg;

    always_ff @(posedge clk)
    begin
        // A end vs B, A start vs B
        m1a_reg   <= PW'(d23x_reg) * PW'(d43y_reg);
        m1b_reg   <= PW'(d23y_reg) * PW'(d43x_reg);
        m2a_reg   <= PW'(d43x_reg) * PW'(d13y_reg);
        m2b_reg   <= PW'(d43y_reg) * PW'(d13x_reg);
        // B end vs A, B start vs A (x3 - x1 is the negated d13)
        m3a_reg   <= PW'(d41x_reg) * PW'(d21y_reg);
        m3b_reg   <= PW'(d41y_reg) * PW'(d21x_reg);
        m4a_reg   <= -(PW'(d21x_reg) * PW'(d13y_reg));
        m4b_reg   <= -(PW'(d21y_reg) * PW'(d13x_reg));
        da_reg    <= PW'(a12_reg) * PW'(d43x_reg);
        db_reg    <= PW'(a34_reg) * PW'(d21x_reg);
        c12_reg   <= CCW'(p12_reg) - CCW'(p21_reg);
        c34_reg   <= CCW'(p34_reg) - CCW'(p43_reg);
        a12_2_reg <= a12_reg;
        a34_2_reg <= a34_reg;
        b12_2_reg <= d21x_reg;
        b34_2_reg <= d43x_reg;
        box2_reg  <= box_reg;
    end

    // ---- stage 3: cross products, determinant, numerator terms ----
    logic v3_reg;
    logic signed [CW-1:0]  cr1_reg, cr2_reg, cr3_reg, cr4_reg, det3_reg;
    logic signed [NPW-1:0] np1_reg, np2_reg, np3_reg, np4_reg;
    logic box3_reg;

    always_ff @(posedge clk)
    begin
        cr1_reg  <= CW'(m1a_reg) - CW'(m1b_reg);
        cr2_reg  <= CW'(m2a_reg) - CW'(m2b_reg);
        cr3_reg  <= CW'(m3a_reg) - CW'(m3b_reg);
        cr4_reg  <= CW'(m4a_reg) - CW'(m4b_reg);
        det3_reg <= CW'(da_reg) - CW'(db_reg);
        np1_reg  <= NPW'(b12_2_reg) * NPW'(c34_reg);
        np2_reg  <= NPW'(b34_2_reg) * NPW'(c12_reg);
        np3_reg  <= NPW'(c12_reg) * NPW'(a34_2_reg);
        np4_reg  <= NPW'(c34_reg) * NPW'(a12_2_reg);
        box3_reg <= box2_reg;
    end

    // ---- stage 4: straddle tests, numerators ----
    logic v4_reg;
    logic signed [NW-1:0] nx_reg, ny_reg;
    logic signed [CW-1:0] det4_reg;
    logic meets4_reg;
    logic side1, side2;

    // A zero cross product counts as on either side
    always_comb
    begin
        side1 = (cr1_reg == '0) || (cr2_reg == '0) || (cr1_reg[CW-1] == cr2_reg[CW-1]);
        side2 = (cr3_reg == '0) || (cr4_reg == '0) || (cr3_reg[CW-1] == cr4_reg[CW-1]);
    end

    always_ff @(posedge clk)
    begin
        nx_reg     <= NW'(np1_reg) - NW'(np2_reg);
        ny_reg     <= NW'(np3_reg) - NW'(np4_reg);
        det4_reg   <= det3_reg;
        meets4_reg <= box3_reg && side1 && side2;
    end

    // ---- stage 5: magnitudes and quotient signs ----
    logic v5_reg;
    logic [NW-1:0] nxm_reg, nym_reg;
    logic [CW-1:0] detm_reg;
    logic negx_reg, negy_reg, meets5_reg, par5_reg;

    always_ff @(posedge clk)
    begin
        nxm_reg    <= nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
        nym_reg    <= ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
        detm_reg   <= det4_reg[CW-1] ? CW'(-det4_reg) : CW'(det4_reg);
        negx_reg   <= nx_reg[NW-1] ^ det4_reg[CW-1];
        negy_reg   <= ny_reg[NW-1] ^ det4_reg[CW-1];
        meets5_reg <= meets4_reg;
        par5_reg   <= (det4_reg == '0);
    end

    // ---- divider: one per axis ----
    logic signed [OUT_BITS-1:0] qx, qy;

    sic_fixdiv u_div_x
    (
        .clk     (clk),
        .num_mag (nxm_reg),
        .den_mag (detm_reg),
        .neg     (negx_reg),
        .quo     (qx)
    );

    sic_fixdiv u_div_y
    (
        .clk     (clk),
        .num_mag (nym_reg),
        .den_mag (detm_reg),
        .neg     (negy_reg),
        .quo     (qy)
    );

    // Side flags ride alongside the divider
    logic vd_reg     [0:DIV_LAT-1];
    logic meetsd_reg [0:DIV_LAT-1];
    logic pard_reg   [0:DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        meetsd_reg[0] <= meets5_reg;
        pard_reg[0]   <= par5_reg;
        for (int k = 1; k < DIV_LAT; k++)
        begin
            meetsd_reg[k] <= meetsd_reg[k-1];
            pard_reg[k]   <= pard_reg[k-1];
        end
    end

    // ---- output register ----
    logic done_reg, meets_reg, parallel_reg;
    logic signed [OUT_BITS-1:0] cross_x_reg, cross_y_reg;

    // Zero determinant: drop the quotient, report the origin
    always_ff @(posedge clk)
    begin
        meets_reg    <= meetsd_reg[DIV_LAT-1];
        parallel_reg <= pard_reg[DIV_LAT-1];
        cross_x_reg  <= pard_reg[DIV_LAT-1] ? '0 : qx;
        cross_y_reg  <= pard_reg[DIV_LAT-1] ? '0 : qy;
    end

    // Valid bits advance every cycle; the pipeline never holds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++)
                vd_reg[k] <= 1'b0;
        end
        else
        begin
            v1_reg    <= start && !busy;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            vd_reg[0] <= v5_reg;
            for (int k = 1; k < DIV_LAT; k++)
                vd_reg[k] <= vd_reg[k-1];
            done_reg  <= vd_reg[DIV_LAT-1];
        end
    end

    assign busy     = 1'b0;
    assign done     = done_reg;
    assign meets    = meets_reg;
    assign parallel = parallel_reg;
    assign cross_x  = cross_x_reg;
    assign cross_y  = cross_y_reg;

endmodule

`default_nettype wire

// ===== bench/tb_segment_intersection_core.sv =====
// ============================================================================
// tb_segment_intersection_core
// Self-checking bench for the segment meet test and crossing point.
// ============================================================================
//
// Drives segment pairs into the core with random gaps between transactions.
// A scoreboard class predicts each result with exact wide integer arithmetic
// and checks every done strobe against the oldest prediction.
// ============================================================================
`default_nettype none

module tb_segment_intersection_core;
    import sic_pkg::*;

    localparam int N_RANDOM  = 500;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 5 + DIV_LAT + 1 + 10;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic                       meets;
        logic                       parallel;
        logic signed [OUT_BITS-1:0] cross_x;
        logic signed [OUT_BITS-1:0] cross_y;
    } crossing_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds predicted crossings in arrival order
    // ------------------------------------------------------------------------
    class crossing_board;
        crossing_t pending[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        // Truncate toward zero, then saturate to the signed output range.
        function automatic logic signed [OUT_BITS-1:0] fix_div(
            logic signed [127:0] num, logic signed [127:0] den);
            logic signed [127:0] q;
            q = (num <<< FRAC_BITS) / den;
            if (q > 128'sd2147483647)
                return 32'sh7fffffff;
            if (q < -128'sd2147483648)
                return 32'sh80000000;
            return q[OUT_BITS-1:0];
        endfunction

        function automatic bit same_side(logic signed [127:0] c1,
                                         logic signed [127:0] c2);
            return c1 == 0 || c2 == 0 || ((c1 > 0) == (c2 > 0));
        endfunction

        function automatic logic signed [127:0] xp(
            logic signed [127:0] ux, logic signed [127:0] uy,
            logic signed [127:0] vx, logic signed [127:0] vy);
            return ux * vy - uy * vx;
        endfunction

        // Note one accepted segment pair and queue its predicted crossing.
        function void note_pair(coord_t ax1, coord_t ay1, coord_t ax2, coord_t ay2,
                                coord_t bx1, coord_t by1, coord_t bx2, coord_t by2);
            logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
            logic signed [127:0] a12, b12, c12, a34, b34, c34, det;
            bit box, s1, s2;
            crossing_t r;
            x1 = ax1; y1 = ay1; x2 = ax2; y2 = ay2;
            x3 = bx1; y3 = by1; x4 = bx2; y4 = by2;
            box = ((x1 < x2 ? x1 : x2) > (x3 < x4 ? x3 : x4) ? (x1 < x2 ? x1 : x2)
                                                              : (x3 < x4 ? x3 : x4))
               <= ((x1 < x2 ? x2 : x1) < (x3 < x4 ? x4 : x3) ? (x1 < x2 ? x2 : x1)
                                                              : (x3 < x4 ? x4 : x3))
               && ((y1 < y2 ? y1 : y2) > (y3 < y4 ? y3 : y4) ? (y1 < y2 ? y1 : y2)
                                                              : (y3 < y4 ? y3 : y4))
               <= ((y1 < y2 ? y2 : y1) < (y3 < y4 ? y4 : y3) ? (y1 < y2 ? y2 : y1)
                                                              : (y3 < y4 ? y4 : y3));
            s1 = same_side(xp(x2 - x3, y2 - y3, x4 - x3, y4 - y3),
                           xp(x4 - x3, y4 - y3, x1 - x3, y1 - y3));
            s2 = same_side(xp(x4 - x1, y4 - y1, x2 - x1, y2 - y1),
                           xp(x2 - x1, y2 - y1, x3 - x1, y3 - y1));
            a12 = y1 - y2; b12 = x2 - x1; c12 = x1 * y2 - x2 * y1;
            a34 = y3 - y4; b34 = x4 - x3; c34 = x3 * y4 - x4 * y3;
            det = a12 * b34 - a34 * b12;
            r.meets = box && s1 && s2;
            if (det == 0)
            begin
                r.parallel = 1'b1;
                r.cross_x  = '0;
                r.cross_y  = '0;
            end
            else
            begin
                r.parallel = 1'b0;
                r.cross_x  = fix_div(b12 * c34 - b34 * c12, det);
                r.cross_y  = fix_div(c12 * a34 - c34 * a12, det);
            end
            pending.push_back(r);
        endfunction

        // Check one strobed result against the oldest prediction.
        function void check_crossing(crossing_t got);
            crossing_t exp_r;
            if (pending.size() == 0)
            begin
                $error("result with no transaction outstanding");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.meets !== exp_r.meets)
            begin
                $error("meets: expected %0d actual %0d", exp_r.meets, got.meets);
                errors++;
            end
            if (got.parallel !== exp_r.parallel)
            begin
                $error("parallel: expected %0d actual %0d", exp_r.parallel, got.parallel);
                errors++;
            end
            if (got.cross_x !== exp_r.cross_x)
            begin
                $error("cross_x: expected %0d actual %0d", exp_r.cross_x, got.cross_x);
                errors++;
            end
            if (got.cross_y !== exp_r.cross_y)
            begin
                $error("cross_y: expected %0d actual %0d", exp_r.cross_y, got.cross_y);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block signals
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    coord_t a_start_x = '0, a_start_y = '0, a_end_x = '0, a_end_y = '0;
    coord_t b_start_x = '0, b_start_y = '0, b_end_x = '0, b_end_y = '0;
    logic done, meets, parallel;
    logic signed [OUT_BITS-1:0] cross_x, cross_y;

    crossing_board board = new();
    int            idle_cycles = 0;

    always #10 clk = ~clk;

    segment_intersection_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .a_start_x (a_start_x),
        .a_start_y (a_start_y),
        .a_end_x   (a_end_x),
        .a_end_y   (a_end_y),
        .b_start_x (b_start_x),
        .b_start_y (b_start_y),
        .b_end_x   (b_end_x),
        .b_end_y   (b_end_y),
        .done      (done),
        .meets     (meets),
        .parallel  (parallel),
        .cross_x   (cross_x),
        .cross_y   (cross_y)
    );

    // Monitor: sample on the edge, note accepted inputs, check strobed results.
    // Inputs change by nonblocking assignment, so values seen here are settled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_pair(a_start_x, a_start_y, a_end_x, a_end_y,
                                b_start_x, b_start_y, b_end_x, b_end_y);
            if (done)
                board.check_crossing('{meets, parallel, cross_x, cross_y});
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("FAIL segment_intersection_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Present one transaction and hold it until the core takes it.
    task automatic send_pair(coord_t ax1, coord_t ay1, coord_t ax2, coord_t ay2,
                             coord_t bx1, coord_t by1, coord_t bx2, coord_t by2,
                             int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        a_start_x <= ax1; a_start_y <= ay1; a_end_x <= ax2; a_end_y <= ay2;
        b_start_x <= bx1; b_start_y <= by1; b_end_x <= bx2; b_end_y <= by2;
        start     <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Random coordinate by mode: small so segments meet often, medium, extreme or full range.
    function automatic coord_t rnd_coord(int mode);
        case (mode)
            0: return coord_t'($urandom_range(0, 40)) - coord_t'(20);
            1: return coord_t'($urandom_range(0, 2000)) - coord_t'(1000);
            2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
            default: return coord_t'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        coord_t c[8];
        int     mode;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: crossing, touching endpoints, collinear, parallel,
        // degenerate points, full-range extremes and saturation.
        send_pair(-10, -10, 10, 10, -10, 10, 10, -10, 0);
        send_pair(0, 0, 10, 0, 10, 0, 10, 10, 0);
        send_pair(0, 0, 10, 0, 5, 0, 20, 0, 0);
        send_pair(0, 0, 10, 0, 0, 5, 10, 5, 0);
        send_pair(3, 3, 3, 3, 3, 3, 3, 3, 0);
        send_pair(0, 0, 10, 0, 20, 5, 21, -5, 1);
        send_pair(0, 0, 1, 1, 0, 1, 1, 0, 0);
        send_pair(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                  16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 0);
        send_pair(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
                  16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 2);
        send_pair(0, 0, 32767, 1, 0, 1, 32767, 3, 0);
        send_pair(0, 0, 32767, 1, 0, 1, -32768, 2, 0);
        send_pair(-32768, 0, -32767, 1, -32768, 1, -32767, 3, 0);
        send_pair(0, 0, 0, 10, 0, 5, 0, 20, 0);
        send_pair(0, 0, 10, 10, 10, 10, 20, 0, 0);
        send_pair(0, 0, 10, 10, 11, 11, 20, 0, 0);
        send_pair(-1, -1, -1, -1, -1, -1, 0, 0, 0);
        send_pair(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555,
                  16'sh0f0f, 16'shf0f0, 16'shf0f0, 16'sh0f0f, 0);

        // Random: mix of small, medium, extreme and full-range coordinates.
        for (int n = 0; n < N_RANDOM; n++)
        begin
            mode = $urandom_range(0, 3);
            for (int k = 0; k < 8; k++)
                c[k] = ($urandom_range(0, 9) == 0) ? rnd_coord($urandom_range(0, 3))
                                                   : rnd_coord(mode);
            // Force some parallel pairs by reusing A's direction for B.
            if ($urandom_range(0, 9) == 0)
            begin
                c[6] = c[4] + (c[2] - c[0]);
                c[7] = c[5] + (c[3] - c[1]);
            end
            send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7],
                      ($urandom_range(0, 4) == 0) ? 0 : pick_gap());
        end
        start <= 1'b0;

        // Drain: wait for every outstanding result, then settle.
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (board.errors == 0)
            $display("PASS segment_intersection_core");
        else
            $display("FAIL segment_intersection_core");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/sic_pkg.sv
rtl/sic_fixdiv.sv
rtl/segment_intersection_core.sv
bench/tb_segment_intersection_core.sv
